### design/ckrle_pkg.sv
// Shared types, constants and the result-entry layout of the color-key RLE encoder.
package ckrle_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int OUT_DEPTH = 1048576;
    localparam int MAX_COUNT = 255;

    localparam int ADDR_W = $clog2(OUT_DEPTH);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = 11;
    localparam int PIX_W  = 8;
    localparam int CNT_B  = 8;

    localparam int MAX_RES = 7;
    localparam int RES_W   = $clog2(MAX_RES + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic
    {
        REG_IMAGE_WIDTH     = 1'b0,
        REG_TRANSPARENT_KEY = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic              ovf;
    } byte_t;

    typedef struct packed
    {
        byte_t [MAX_RES-1:0] slot;
        logic  [RES_W-1:0]   count;
        logic                done;
    } entry_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] addr;
        logic [PTR_W-1:0]  ptr;
        logic              ovf;
    } take_t;

endpackage

### design/ckrle_pixel_if.sv
// Pixel input channel with valid/ready handshake.
interface ckrle_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [ckrle_pkg::PIX_W-1:0] pixel;
    logic                       end_of_image;

    modport source (output valid, output pixel, output end_of_image, input ready);
    modport sink   (input valid, input pixel, input end_of_image, output ready);
endinterface

### design/ckrle_write_if.sv
// Byte-write output channel with valid/ready handshake.
interface ckrle_write_if;
    logic                         valid;
    logic                         ready;
    logic [ckrle_pkg::ADDR_W-1:0] write_address;
    logic [ckrle_pkg::PIX_W-1:0]  write_data;
    logic                         image_done;
    logic                         overflow;
    logic                         last_of_item;

    modport source (output valid, output write_address, output write_data,
                    output image_done, output overflow, output last_of_item, input ready);
    modport sink   (input valid, input write_address, input write_data,
                    input image_done, input overflow, input last_of_item, output ready);
endinterface

### design/ckrle_front.sv
// Front end: configuration registers, run/skip tracking and per-pixel write list building.
module ckrle_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ckrle_pkg::WID_W-1:0]  cfg_data,
    ckrle_pixel_if.sink                  pix,
    input  logic                         q_room,
    output logic                         q_push,
    output ckrle_pkg::entry_t            q_entry
);

    logic [ckrle_pkg::WID_W-1:0]  width_reg;
    logic [ckrle_pkg::PIX_W-1:0]  key_reg;

    logic [ckrle_pkg::COL_W-1:0]  col_reg,   col_next;
    logic                         inrun_reg, inrun_next;
    logic [ckrle_pkg::CNT_B-1:0]  skip_reg,  skip_next;
    logic [ckrle_pkg::CNT_B-1:0]  run_reg,   run_next;
    logic [ckrle_pkg::CNT_B-1:0]  hskip_reg, hskip_next;
    logic [ckrle_pkg::ADDR_W-1:0] haddr_reg, haddr_next;
    logic [ckrle_pkg::PTR_W-1:0]  wp_reg,    wp_next;
    logic [ckrle_pkg::PTR_W-1:0]  lne_reg,   lne_next;
    logic                         rho_reg,   rho_next;
    logic                         ovf_reg,   ovf_next;

    logic [ckrle_pkg::WID_W-1:0]  eff_width;
    logic                         accept;
    ckrle_pkg::entry_t            ent;

    function automatic ckrle_pkg::take_t take_slot(input logic [ckrle_pkg::PTR_W-1:0] ptr,
                                                   input logic ovf);
        ckrle_pkg::take_t t;
        if (ptr < ckrle_pkg::PTR_W'(ckrle_pkg::OUT_DEPTH))
        begin
            t.addr = ptr[ckrle_pkg::ADDR_W-1:0];
            t.ptr  = ptr + 1'b1;
            t.ovf  = ovf;
        end
        else
        begin
            t.addr = ckrle_pkg::ADDR_W'(ckrle_pkg::OUT_DEPTH - 1);
            t.ptr  = ptr;
            t.ovf  = 1'b1;
        end
        return t;
    endfunction

    function automatic logic [ckrle_pkg::ADDR_W-1:0] clamp_addr(
        input logic [ckrle_pkg::PTR_W:0] a);
        logic [ckrle_pkg::ADDR_W-1:0] r;
        if (a < (ckrle_pkg::PTR_W + 1)'(ckrle_pkg::OUT_DEPTH))
            r = a[ckrle_pkg::ADDR_W-1:0];
        else
            r = ckrle_pkg::ADDR_W'(ckrle_pkg::OUT_DEPTH - 1);
        return r;
    endfunction

    function automatic ckrle_pkg::byte_t mk_byte(input logic [ckrle_pkg::ADDR_W-1:0] addr,
                                                 input logic [ckrle_pkg::PIX_W-1:0] data,
                                                 input logic ovf);
        ckrle_pkg::byte_t b;
        b.addr = addr;
        b.data = data;
        b.ovf  = ovf;
        return b;
    endfunction

    always_comb
    begin
        if (width_reg == '0)
            eff_width = ckrle_pkg::WID_W'(1);
        else if (width_reg > ckrle_pkg::WID_W'(ckrle_pkg::MAX_WIDTH))
            eff_width = ckrle_pkg::WID_W'(ckrle_pkg::MAX_WIDTH);
        else
            eff_width = width_reg;
    end

    assign pix.ready = q_room;
    assign accept    = pix.valid && q_room;

    always_comb
    begin
        ckrle_pkg::take_t          t;
        logic [ckrle_pkg::RES_W-1:0] k;
        logic                      row_end;

        col_next   = col_reg;
        inrun_next = inrun_reg;
        skip_next  = skip_reg;
        run_next   = run_reg;
        hskip_next = hskip_reg;
        haddr_next = haddr_reg;
        wp_next    = wp_reg;
        lne_next   = lne_reg;
        rho_next   = rho_reg;
        ovf_next   = ovf_reg;
        ent        = '0;
        k          = '0;
        t          = '0;
        row_end    = ({1'b0, col_reg} + 1'b1 >= eff_width) || pix.end_of_image;

        if (pix.pixel == key_reg)
        begin
            if (inrun_next)
            begin
                ent.slot[k] = mk_byte(haddr_next, hskip_next, ovf_next);
                k = k + 1'b1;
                ent.slot[k] = mk_byte(clamp_addr({1'b0, 1'b0, haddr_next} + 1'b1),
                                      run_next, ovf_next);
                k = k + 1'b1;
                inrun_next = 1'b0;
                run_next   = '0;
                hskip_next = '0;
                lne_next   = wp_next;
            end
            if (skip_next == ckrle_pkg::CNT_B'(ckrle_pkg::MAX_COUNT))
            begin
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                ent.slot[k] = mk_byte(t.addr, ckrle_pkg::PIX_W'(ckrle_pkg::MAX_COUNT), ovf_next);
                k = k + 1'b1;
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                ent.slot[k] = mk_byte(t.addr, '0, ovf_next);
                k = k + 1'b1;
                skip_next = '0;
            end
            skip_next = skip_next + 1'b1;
        end
        else
        begin
            rho_next = 1'b1;
            if (inrun_next && run_next == ckrle_pkg::CNT_B'(ckrle_pkg::MAX_COUNT))
            begin
                ent.slot[k] = mk_byte(haddr_next, hskip_next, ovf_next);
                k = k + 1'b1;
                ent.slot[k] = mk_byte(clamp_addr({1'b0, 1'b0, haddr_next} + 1'b1),
                                      run_next, ovf_next);
                k = k + 1'b1;
                inrun_next = 1'b0;
                run_next   = '0;
                hskip_next = '0;
            end
            if (!inrun_next)
            begin
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                haddr_next = t.addr;
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                hskip_next = skip_next;
                skip_next  = '0;
                run_next   = '0;
                inrun_next = 1'b1;
            end
            t = take_slot(wp_next, ovf_next);
            wp_next = t.ptr;
            ovf_next = t.ovf;
            ent.slot[k] = mk_byte(t.addr, pix.pixel, ovf_next);
            k = k + 1'b1;
            run_next = run_next + 1'b1;
        end

        if (row_end)
        begin
            if (inrun_next)
            begin
                ent.slot[k] = mk_byte(haddr_next, hskip_next, ovf_next);
                k = k + 1'b1;
                ent.slot[k] = mk_byte(clamp_addr({1'b0, 1'b0, haddr_next} + 1'b1),
                                      run_next, ovf_next);
                k = k + 1'b1;
                lne_next = wp_next;
            end
            else
            begin
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                ent.slot[k] = mk_byte(t.addr, skip_next, ovf_next);
                k = k + 1'b1;
                t = take_slot(wp_next, ovf_next);
                wp_next = t.ptr;
                ovf_next = t.ovf;
                ent.slot[k] = mk_byte(t.addr, '0, ovf_next);
                k = k + 1'b1;
                if (rho_next)
                    lne_next = wp_next;
            end
            col_next   = '0;
            inrun_next = 1'b0;
            skip_next  = '0;
            run_next   = '0;
            hskip_next = '0;
            rho_next   = 1'b0;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end

        if (pix.end_of_image)
        begin
            ent.slot[k] = mk_byte(clamp_addr({1'b0, lne_next}), '0, ovf_next);
            k = k + 1'b1;
            ent.slot[k] = mk_byte(clamp_addr({1'b0, lne_next} + 1'b1), '0, ovf_next);
            k = k + 1'b1;
            haddr_next = '0;
            wp_next    = '0;
            lne_next   = '0;
            ovf_next   = 1'b0;
        end

        ent.count = k;
        ent.done  = pix.end_of_image;
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= ckrle_pkg::WID_W'(64);
            key_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ckrle_pkg::reg_index_t'(cfg_index))
                ckrle_pkg::REG_IMAGE_WIDTH:     width_reg <= cfg_data;
                ckrle_pkg::REG_TRANSPARENT_KEY: key_reg   <= cfg_data[ckrle_pkg::PIX_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            inrun_reg <= 1'b0;
            skip_reg  <= '0;
            run_reg   <= '0;
            hskip_reg <= '0;
            haddr_reg <= '0;
            wp_reg    <= '0;
            lne_reg   <= '0;
            rho_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            inrun_reg <= inrun_next;
            skip_reg  <= skip_next;
            run_reg   <= run_next;
            hskip_reg <= hskip_next;
            haddr_reg <= haddr_next;
            wp_reg    <= wp_next;
            lne_reg   <= lne_next;
            rho_reg   <= rho_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### design/ckrle_queue.sv
// Short queue of per-pixel write lists between the front end and the back end.
module ckrle_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ckrle_pkg::entry_t push_entry,
    output logic              room,
    input  logic              pop,
    output logic              head_valid,
    output ckrle_pkg::entry_t head
);

    ckrle_pkg::entry_t             slot_reg [ckrle_pkg::Q_DEPTH];
    logic [ckrle_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ckrle_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ckrle_pkg::Q_CNT_W-1:0] cnt_reg,    cnt_next;

    assign room       = cnt_reg < ckrle_pkg::Q_CNT_W'(ckrle_pkg::Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == ckrle_pkg::Q_PTR_W'(ckrle_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == ckrle_pkg::Q_PTR_W'(ckrle_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + ckrle_pkg::Q_CNT_W'(push) - ckrle_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### design/ckrle_back.sv
// Back end: walks each queued write list and drives one byte write per cycle while the write port is ready.
module ckrle_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ckrle_pkg::entry_t head,
    output logic              pop,
    ckrle_write_if.source     wr
);

    logic [ckrle_pkg::RES_W-1:0]  idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    logic [ckrle_pkg::ADDR_W-1:0] addr_reg;
    logic [ckrle_pkg::PIX_W-1:0]  data_reg;
    logic                         done_reg;
    logic                         ovf_reg;
    logic                         last_reg;

    logic                         load;
    logic                         take;
    logic                         last;
    ckrle_pkg::byte_t             cur;

    assign load = !valid_reg || wr.ready;
    assign take = load && head_valid;
    assign last = idx_reg == head.count - 1'b1;
    assign cur  = head.slot[idx_reg];
    assign pop  = take && last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
            valid_next = head_valid;
        if (take)
            idx_next = last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            addr_reg <= cur.addr;
            data_reg <= cur.data;
            ovf_reg  <= cur.ovf;
            last_reg <= last;
            done_reg <= last && head.done;
        end
    end

    assign wr.valid         = valid_reg;
    assign wr.write_address = addr_reg;
    assign wr.write_data    = data_reg;
    assign wr.image_done    = done_reg;
    assign wr.overflow      = ovf_reg;
    assign wr.last_of_item  = last_reg;

endmodule

### design/colorkey_rle_encoder.sv
// Top level of the color-key run-length encoder for 8-bit pixels.
// An accepted pixel's write list passes through the queue and the back end's output register before it is written.
// The front end takes one pixel per cycle while the two-entry queue has room.
// The write port drives one byte per cycle while its ready is high, so a pixel with k writes holds it for k bytes.
// Reset clears all run state and the queue, sets the width to 64 and the key to 0.
module colorkey_rle_encoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ckrle_pkg::WID_W-1:0] cfg_data,
    ckrle_pixel_if.sink                 pix,
    ckrle_write_if.source               wr
);

    logic              q_push;
    logic              q_room;
    logic              q_pop;
    logic              q_head_valid;
    ckrle_pkg::entry_t q_push_entry;
    ckrle_pkg::entry_t q_head;

    ckrle_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .q_room    (q_room),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    ckrle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .room       (q_room),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ckrle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .wr         (wr)
    );

    // The queue must never be written while it is full.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> q_room)
        else $error("queue written while full");

    // A list is only retired while it is present.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head_valid)
        else $error("queue retired while empty");

    // The image-done byte is the final zero terminator byte of its pixel.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.image_done) |-> (wr.last_of_item && wr.write_data == '0))
        else $error("image done on a byte that is not the terminator");

endmodule

### tb/ckrle_encode_monitor.sv
// Predicts the byte writes of the color-key RLE encoder and checks them against the write channel.
module ckrle_encode_monitor
    import ckrle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [WID_W-1:0] cfg_data,
    ckrle_pixel_if           pix,
    ckrle_write_if           wr,
    output int               fail_count,
    output int               pending_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 100;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic              done;
        logic              ovf;
        logic              last_of_item;
    } byte_write_t;

    byte_write_t expected_writes[$];
    byte_write_t pixel_writes[$];

    logic [WID_W-1:0]  image_width;
    logic [PIX_W-1:0]  key;
    logic [COL_W-1:0]  column;
    logic              in_run;
    logic [CNT_B-1:0]  skip_count;
    logic [CNT_B-1:0]  run_count;
    logic [CNT_B-1:0]  header_skip;
    logic [ADDR_W-1:0] header_addr;
    logic [PTR_W-1:0]  write_ptr;
    logic [PTR_W-1:0]  nonblank_end;
    logic              row_has_opaque;
    logic              overflow_seen;

    function automatic logic [ADDR_W-1:0] clamp_addr(input logic [PTR_W-1:0] a);
        return (a < PTR_W'(OUT_DEPTH)) ? a[ADDR_W-1:0] : ADDR_W'(OUT_DEPTH - 1);
    endfunction

    function automatic logic [ADDR_W-1:0] take_slot();
        logic [ADDR_W-1:0] a;
        if (write_ptr < PTR_W'(OUT_DEPTH))
        begin
            a = write_ptr[ADDR_W-1:0];
            write_ptr = write_ptr + 1'b1;
        end
        else
        begin
            overflow_seen = 1'b1;
            a = ADDR_W'(OUT_DEPTH - 1);
        end
        return a;
    endfunction

    function automatic void emit_byte(input logic [ADDR_W-1:0] a, input logic [PIX_W-1:0] d);
        byte_write_t w;
        w.addr = a;
        w.data = d;
        w.done = 1'b0;
        w.ovf = overflow_seen;
        w.last_of_item = 1'b0;
        pixel_writes.push_back(w);
    endfunction

    function automatic void close_run();
        emit_byte(header_addr, header_skip);
        emit_byte(clamp_addr(PTR_W'(header_addr) + 1'b1), run_count);
        in_run = 1'b0;
        run_count = '0;
        header_skip = '0;
    endfunction

    function automatic void clear_row();
        column = '0;
        in_run = 1'b0;
        skip_count = '0;
        run_count = '0;
        header_skip = '0;
        row_has_opaque = 1'b0;
    endfunction

    function automatic void clear_image();
        clear_row();
        header_addr = '0;
        write_ptr = '0;
        nonblank_end = '0;
        overflow_seen = 1'b0;
    endfunction

    function automatic void encode_pixel(input logic [PIX_W-1:0] px, input logic eoi);
        int w;
        int n;
        w = (image_width == '0) ? 1 : int'(image_width);
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        pixel_writes.delete();

        if (px == key)
        begin
            if (in_run)
            begin
                close_run();
                nonblank_end = write_ptr;
            end
            if (skip_count >= MAX_COUNT)
            begin
                emit_byte(take_slot(), PIX_W'(MAX_COUNT));
                emit_byte(take_slot(), '0);
                skip_count = '0;
            end
            skip_count = skip_count + 1'b1;
        end
        else
        begin
            row_has_opaque = 1'b1;
            if (in_run && run_count >= MAX_COUNT)
                close_run();
            if (!in_run)
            begin
                header_addr = take_slot();
                void'(take_slot());
                header_skip = skip_count;
                skip_count = '0;
                run_count = '0;
                in_run = 1'b1;
            end
            emit_byte(take_slot(), px);
            run_count = run_count + 1'b1;
        end

        if (int'(column) + 1 >= w || eoi)
        begin
            if (in_run)
            begin
                close_run();
                nonblank_end = write_ptr;
            end
            else
            begin
                emit_byte(take_slot(), skip_count);
                emit_byte(take_slot(), '0);
                if (row_has_opaque)
                    nonblank_end = write_ptr;
            end
            clear_row();
        end
        else
        begin
            column = column + 1'b1;
        end

        if (eoi)
        begin
            emit_byte(clamp_addr(nonblank_end), '0);
            emit_byte(clamp_addr(nonblank_end + 1'b1), '0);
            pixel_writes[pixel_writes.size() - 1].done = 1'b1;
            clear_image();
        end

        n = pixel_writes.size();
        if (n > 0)
            pixel_writes[n - 1].last_of_item = 1'b1;
        foreach (pixel_writes[i])
            expected_writes.push_back(pixel_writes[i]);
    endfunction

    function automatic void check_write();
        byte_write_t e;
        if (expected_writes.size() == 0)
        begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t: unexpected write, actual addr=%05h data=%02h done=%0b ovf=%0b last=%0b",
                         $time, wr.write_address, wr.write_data, wr.image_done, wr.overflow,
                         wr.last_of_item);
            fail_count++;
        end
        else
        begin
            e = expected_writes.pop_front();
            if (wr.write_address !== e.addr || wr.write_data !== e.data
                || wr.image_done !== e.done || wr.overflow !== e.ovf
                || wr.last_of_item !== e.last_of_item)
            begin
                if (fail_count < REPORT_LIMIT)
                    $display("%0t: write mismatch, expected addr=%05h data=%02h done=%0b ovf=%0b last=%0b, actual addr=%05h data=%02h done=%0b ovf=%0b last=%0b",
                             $time, e.addr, e.data, e.done, e.ovf, e.last_of_item,
                             wr.write_address, wr.write_data, wr.image_done, wr.overflow,
                             wr.last_of_item);
                fail_count++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width = WID_W'(64);
            key = '0;
            clear_image();
            expected_writes.delete();
            fail_count = 0;
            pending_writes <= 0;
        end
        else
        begin
            if (wr.valid && wr.ready)
                check_write();
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    image_width = cfg_data;
                else
                    key = cfg_data[PIX_W-1:0];
            end
            if (pix.valid && pix.ready)
                encode_pixel(pix.pixel, pix.end_of_image);
            pending_writes <= expected_writes.size();
        end
    end

endmodule

### tb/testbench.sv
// Color-key RLE encoder testbench top: clock, reset, config, pixel, ready stimulus, verdict.
module testbench;
    import ckrle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_SPAN      = 256;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [WID_W-1:0] cfg_data;

    bit               calm = 1'b0;
    int               burst_left = 0;
    logic [PIX_W-1:0] cur_key = '0;
    logic [15:0]      ready_pattern;
    int               pattern_age;
    int               idle_cycles = 0;
    int               fail_count;
    int               pending_writes;
    int               random_sent;
    int               image_items;

    ckrle_pixel_if pix_ch ();
    ckrle_write_if wr_ch ();

    colorkey_rle_encoder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .wr        (wr_ch)
    );

    ckrle_encode_monitor encode_monitor
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix            (pix_ch),
        .wr             (wr_ch),
        .fail_count     (fail_count),
        .pending_writes (pending_writes)
    );

    always #6 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ch.ready <= 1'b0;
            ready_pattern <= '1;
            pattern_age <= 0;
        end
        else
        begin
            wr_ch.ready <= ready_pattern[0];
            if (pattern_age == 63)
            begin
                pattern_age <= 0;
                if (calm)
                    ready_pattern <= '1;
                else
                    case ($urandom_range(0, 3))
                        0: ready_pattern <= '1;
                        1: ready_pattern <= 16'($urandom) | 16'h0001;
                        2: ready_pattern <= 16'h8001;
                        default: ready_pattern <= 16'h3C3C;
                    endcase
            end
            else
            begin
                pattern_age <= pattern_age + 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] value, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= value;
        pix_ch.end_of_image <= eoi;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    task automatic settle();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_writes != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [WID_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_key(input logic [PIX_W-1:0] value);
        cur_key = value;
        write_reg(REG_TRANSPARENT_KEY, {3'($urandom), value});
    endtask

    task automatic push_span(input int count, input bit transparent, input bit close_image);
        int i;
        for (i = 0; i < count; i++)
            push_pixel(transparent ? cur_key : cur_key + 8'($urandom_range(1, 255)),
                       close_image && i == count - 1);
    endtask

    task automatic random_image(output int sent);
        int               w;
        int               n;
        int               i;
        int               change_at;
        bit               noise;
        bit               blank;
        bit               opaque;
        logic [PIX_W-1:0] value;
        settle();
        calm <= ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 1);
            8, 9: w = $urandom_range(13, 40);
            default: w = $urandom_range(2, 12);
        endcase
        write_reg(REG_IMAGE_WIDTH, WID_W'(w));
        if ($urandom_range(0, 1) == 1)
            case ($urandom_range(0, 3))
                0: set_key(8'h00);
                1: set_key(8'hFF);
                default: set_key(8'($urandom));
            endcase
        if (w == 0)
            w = 1;
        n = w * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, n);
        noise = ($urandom_range(0, 4) == 0);
        change_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : -1;
        blank = 1'b0;
        opaque = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (i == change_at)
            begin
                settle();
                write_reg(REG_IMAGE_WIDTH, WID_W'($urandom_range(1, 12)));
                if ($urandom_range(0, 1) == 1)
                    set_key(8'($urandom));
            end
            if (i % w == 0)
            begin
                blank = ($urandom_range(0, 3) == 0);
                opaque = $urandom_range(0, 1);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                opaque = !opaque;
            end
            if (noise)
                value = 8'($urandom);
            else if (blank || !opaque)
                value = cur_key;
            else
                value = cur_key + 8'($urandom_range(1, 255));
            push_pixel(value, i == n - 1);
        end
        sent = n;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        pix_ch.end_of_image <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_IMAGE_WIDTH, WID_W'(4));
        set_key(8'h00);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'h01, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_span(4, 1'b1, 1'b0);
        push_span(4, 1'b1, 1'b1);

        settle();
        set_key(8'hFF);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h80, 1'b1);

        settle();
        write_reg(REG_IMAGE_WIDTH, '0);
        push_pixel(8'hFF, 1'b1);
        push_pixel(8'h01, 1'b0);
        push_pixel(8'hFF, 1'b1);

        settle();
        write_reg(REG_IMAGE_WIDTH, WID_W'(8));
        push_pixel(8'h11, 1'b0);
        push_pixel(8'h22, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h33, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, WID_W'(2));
        push_pixel(8'h44, 1'b0);
        push_pixel(8'h55, 1'b1);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            random_image(image_items);
            random_sent += image_items;
        end

        settle();
        calm <= 1'b0;
        write_reg(REG_IMAGE_WIDTH, '1);
        set_key(8'($urandom));
        push_span(LONG_SPAN, 1'b1, 1'b0);
        push_span(LONG_SPAN, 1'b0, 1'b1);

        settle();
        write_reg(REG_IMAGE_WIDTH, WID_W'(1));
        set_key(8'h5A);
        for (int i = 0; i < 20; i++)
            push_pixel(($urandom_range(0, 3) == 0) ? cur_key : 8'($urandom), i == 19);

        settle();
        write_reg(REG_IMAGE_WIDTH, WID_W'(3));
        push_span(2, 1'b0, 1'b0);
        push_span(1, 1'b1, 1'b1);

        settle();
        if (fail_count == 0 && pending_writes == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
